### sv/radiotap_header_parser_top_defines.svh
// ----------------------------------------------------------------------------
// radiotap_header_parser_top_defines
// Assertion macros shared by the radiotap header parser RTL.
// ----------------------------------------------------------------------------
`ifndef RADIOTAP_HEADER_PARSER_TOP_DEFINES_SVH
`define RADIOTAP_HEADER_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define RHP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhp assertion failed");
// antecedent implies consequent in the following cycle
`define RHP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rhp assertion failed");
`else
`define RHP_ASSERT_IMP(lbl, ante, cons)
`define RHP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/rhp_pkg.sv
// ----------------------------------------------------------------------------
// rhp_pkg
// Types and constants of the radiotap header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhp_pkg;

	// frame bytes at this offset and beyond are dropped
	localparam int MAX_FRAME = 4096;
	localparam int OFF_W     = $clog2(MAX_FRAME + 1);

	// fixed header offsets
	localparam int OFF_HLEN_LO = 2;
	localparam int OFF_HLEN_HI = 3;
	localparam int OFF_BITS_LO = 4;
	localparam int OFF_BITS_HI = 5;
	localparam int MIN_HDR     = 8;
	localparam int FCS_BYTES   = 4;

	// present-bitmap field numbers
	localparam logic [3:0] FLD_TSFT    = 4'd0;
	localparam logic [3:0] FLD_FLAGS   = 4'd1;
	localparam logic [3:0] FLD_RATE    = 4'd2;
	localparam logic [3:0] FLD_CHANNEL = 4'd3;
	localparam logic [3:0] FLD_FHSS    = 4'd4;
	localparam logic [3:0] FLD_SIGNAL  = 4'd5;
	localparam logic [3:0] FLD_NOISE   = 4'd6;
	localparam logic [3:0] FLD_LOCK    = 4'd7;
	localparam logic [3:0] FLD_TXATT   = 4'd8;
	localparam logic [3:0] FLD_DBTXATT = 4'd9;
	localparam logic [3:0] FLD_NONE    = 4'd12;
	localparam int         FLD_COUNT   = 12;

	// flags field and channel flags
	localparam logic [7:0]  FLAG_FCS = 8'h10;
	localparam logic [15:0] CH_TURBO = 16'h0010;
	localparam logic [15:0] CH_CCK   = 16'h0020;
	localparam logic [15:0] CH_OFDM  = 16'h0040;
	localparam logic [15:0] CH_2GHZ  = 16'h0080;
	localparam logic [15:0] CH_5GHZ  = 16'h0100;
	localparam logic [15:0] CH_DYN   = 16'h0400;
	localparam logic [15:0] CH_GFSK  = 16'h0800;

	// carrier classes
	localparam logic [2:0] CAR_UNKNOWN = 3'd0;
	localparam logic [2:0] CAR_FHSS    = 3'd1;
	localparam logic [2:0] CAR_A       = 3'd2;
	localparam logic [2:0] CAR_BPLUS   = 3'd3;
	localparam logic [2:0] CAR_B       = 3'd4;
	localparam logic [2:0] CAR_G       = 3'd5;

	// encoding classes
	localparam logic [2:0] ENC_UNKNOWN = 3'd0;
	localparam logic [2:0] ENC_CCK     = 3'd1;
	localparam logic [2:0] ENC_OFDM    = 3'd2;
	localparam logic [2:0] ENC_DYN     = 3'd3;
	localparam logic [2:0] ENC_GFSK    = 3'd4;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_HDR_SHORT = 3'd2,
		ST_OVERRUN   = 3'd3,
		ST_FCS_SHORT = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		status_t           status;
		logic [15:0]       frequency;
		logic [2:0]        carrier;
		logic [2:0]        encoding;
		logic [9:0]        data_rate;
		logic signed [7:0] signal_level;
		logic signed [7:0] noise_level;
		logic              fcs_present;
		logic [12:0]       payload_length;
		logic [3:0]        seen_mask;
	} out_beat_t;

endpackage

### sv/radiotap_header_parser_top.sv
// ----------------------------------------------------------------------------
// radiotap_header_parser_top
// Byte-serial radiotap header parser with one summary beat per frame.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one frame byte per beat, header
//   first; last_byte marks the final byte of a frame.
//   out channel (out_valid/out_ready/out_data): one summary beat per frame,
//   raised for the beat carrying last_byte.
// Throughput: one byte per cycle across frame boundaries, except that a
//   last byte waits while an unaccepted summary holds the result register.
// The summary for a frame is written to the result register, which drives
//   out_data, as its last byte leaves the input register.
// Only the final byte of a frame needs a free result register; ordinary
//   bytes keep flowing while a summary waits. When the receiver stalls with
//   a summary pending, a following last byte holds in the input register and
//   in_ready drops until the summary is taken.
// Reset: all parse state clears, both channels come up empty, and the first
//   byte after reset is taken as offset zero of a new frame.
// Bytes at offsets of MAX_FRAME and beyond are dropped but a last byte there
//   still closes the frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "radiotap_header_parser_top_defines.svh"

module radiotap_header_parser_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rhp_pkg::in_beat_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rhp_pkg::out_beat_t out_data
);

	localparam int OW = rhp_pkg::OFF_W;

	// lowest present bit at or above from, or none
	function automatic logic [3:0] next_field(input logic [11:0] bits, input logic [3:0] from);
		logic [3:0] r;
		logic       found;
		r     = rhp_pkg::FLD_NONE;
		found = 1'b0;
		for (int i = 0; i < rhp_pkg::FLD_COUNT; i++) begin
			if (!found && bits[i] && (4'(i) >= from)) begin
				r     = 4'(i);
				found = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [3:0] fld_size(input logic [3:0] f);
		logic [3:0] s;
		unique case (f) inside
			rhp_pkg::FLD_TSFT:    s = 4'd8;
			rhp_pkg::FLD_CHANNEL: s = 4'd4;
			rhp_pkg::FLD_FHSS, rhp_pkg::FLD_LOCK, rhp_pkg::FLD_TXATT,
			rhp_pkg::FLD_DBTXATT: s = 4'd2;
			default:              s = 4'd1;
		endcase
		return s;
	endfunction

	function automatic logic [2:0] fld_align_mask(input logic [3:0] f);
		logic [2:0] m;
		unique case (f) inside
			rhp_pkg::FLD_TSFT: m = 3'd7;
			rhp_pkg::FLD_CHANNEL, rhp_pkg::FLD_FHSS, rhp_pkg::FLD_LOCK,
			rhp_pkg::FLD_TXATT, rhp_pkg::FLD_DBTXATT: m = 3'd1;
			default:           m = 3'd0;
		endcase
		return m;
	endfunction

	function automatic logic [2:0] carrier_of(input logic [15:0] f);
		logic [2:0] c;
		if ((f & (rhp_pkg::CH_2GHZ | rhp_pkg::CH_GFSK)) == (rhp_pkg::CH_2GHZ | rhp_pkg::CH_GFSK))
			c = rhp_pkg::CAR_FHSS;
		else if ((f & (rhp_pkg::CH_5GHZ | rhp_pkg::CH_OFDM))
				== (rhp_pkg::CH_5GHZ | rhp_pkg::CH_OFDM))
			c = rhp_pkg::CAR_A;
		else if ((f & (rhp_pkg::CH_2GHZ | rhp_pkg::CH_CCK | rhp_pkg::CH_TURBO))
				== (rhp_pkg::CH_2GHZ | rhp_pkg::CH_CCK | rhp_pkg::CH_TURBO))
			c = rhp_pkg::CAR_BPLUS;
		else if ((f & (rhp_pkg::CH_2GHZ | rhp_pkg::CH_CCK)) == (rhp_pkg::CH_2GHZ | rhp_pkg::CH_CCK))
			c = rhp_pkg::CAR_B;
		else if ((f & (rhp_pkg::CH_2GHZ | rhp_pkg::CH_OFDM))
				== (rhp_pkg::CH_2GHZ | rhp_pkg::CH_OFDM))
			c = rhp_pkg::CAR_G;
		else if ((f & (rhp_pkg::CH_2GHZ | rhp_pkg::CH_DYN)) == (rhp_pkg::CH_2GHZ | rhp_pkg::CH_DYN))
			c = rhp_pkg::CAR_G;
		else
			c = rhp_pkg::CAR_UNKNOWN;
		return c;
	endfunction

	function automatic logic [2:0] encoding_of(input logic [15:0] f);
		logic [2:0] e;
		if ((f & rhp_pkg::CH_CCK) != 16'd0)       e = rhp_pkg::ENC_CCK;
		else if ((f & rhp_pkg::CH_OFDM) != 16'd0) e = rhp_pkg::ENC_OFDM;
		else if ((f & rhp_pkg::CH_DYN) != 16'd0)  e = rhp_pkg::ENC_DYN;
		else if ((f & rhp_pkg::CH_GFSK) != 16'd0) e = rhp_pkg::ENC_GFSK;
		else                                      e = rhp_pkg::ENC_UNKNOWN;
		return e;
	endfunction

	// input register
	logic              s1_valid_q;
	rhp_pkg::in_beat_t s1_q;
	logic              s1_go;

	// parse state
	logic [OW-1:0] off_q, off_d;
	logic [15:0]   hlen_q, hlen_d;
	logic [11:0]   fbits_q, fbits_d;
	logic          done_q, done_d;
	logic          overrun_q, overrun_d;
	logic [3:0]    cursor_q, cursor_d;
	logic [3:0]    count_q, count_d;
	logic [31:0]   gather_q, gather_d;
	logic [15:0]   freq_q, freq_d;
	logic [15:0]   chflags_q, chflags_d;
	logic [7:0]    rate_q, rate_d;
	logic [7:0]    signal_q, signal_d;
	logic [7:0]    noise_q, noise_d;
	logic          fcs_q, fcs_d;
	logic [3:0]    seen_q, seen_d;

	// result register
	logic               out_valid_q;
	rhp_pkg::out_beat_t out_q;
	rhp_pkg::out_beat_t result;

	// working values
	logic [7:0]  b;
	logic [31:0] gather_new;
	logic [3:0]  count_new;
	logic [16:0] len17;
	logic [16:0] hsum17;
	logic [15:0] plen16;
	logic [5:0]  rate_half;

	// handshake: only a last byte waits for the result register
	assign s1_go    = s1_valid_q && (!s1_q.last_byte || !out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_go;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign b         = s1_q.frame_byte;

	// per-byte header bookkeeping
	always_comb begin
		off_d      = off_q;
		hlen_d     = hlen_q;
		fbits_d    = fbits_q;
		done_d     = done_q;
		overrun_d  = overrun_q;
		cursor_d   = cursor_q;
		count_d    = count_q;
		gather_d   = gather_q;
		freq_d     = freq_q;
		chflags_d  = chflags_q;
		rate_d     = rate_q;
		signal_d   = signal_q;
		noise_d    = noise_q;
		fcs_d      = fcs_q;
		seen_d     = seen_q;
		gather_new = gather_q;
		count_new  = count_q + 4'd1;
		if (off_q < OW'(rhp_pkg::MAX_FRAME)) begin
			off_d = off_q + OW'(1);
			if (off_q == OW'(rhp_pkg::OFF_HLEN_LO)) hlen_d[7:0]  = b;
			if (off_q == OW'(rhp_pkg::OFF_HLEN_HI)) hlen_d[15:8] = b;
			if (off_q == OW'(rhp_pkg::OFF_BITS_LO)) fbits_d[7:0]  = b;
			if (off_q == OW'(rhp_pkg::OFF_BITS_HI)) fbits_d[11:8] = b[3:0];
			if (!done_q && !overrun_q) begin
				// last byte of a present word decides the chain
				if (off_q >= OW'(rhp_pkg::OFF_BITS_LO) && off_q[1:0] == 2'b11) begin
					if (hlen_d < 16'(rhp_pkg::MIN_HDR)) begin
						overrun_d = 1'b1;
					end else if (b[7]) begin
						if ((17'(off_q) + 17'd1) > {1'b0, hlen_d})
							overrun_d = 1'b1;
					end else begin
						done_d   = 1'b1;
						cursor_d = next_field(fbits_d, 4'd0);
						count_d  = 4'd0;
						gather_d = 32'd0;
					end
				end
			end else if (done_q && cursor_q < rhp_pkg::FLD_NONE
					&& 16'(off_q) < hlen_q) begin
				// gather field bytes once aligned
				if (!(count_q == 4'd0 && (off_q[2:0] & fld_align_mask(cursor_q)) != 3'd0)) begin
					if (count_q < 4'd4)
						gather_new = gather_q | (32'(b) << {count_q[1:0], 3'b000});
					if (count_new >= fld_size(cursor_q)) begin
						case (cursor_q)
							rhp_pkg::FLD_FLAGS: begin
								if ((gather_new[7:0] & rhp_pkg::FLAG_FCS) != 8'd0)
									fcs_d = 1'b1;
							end
							rhp_pkg::FLD_RATE: begin
								rate_d    = gather_new[7:0];
								seen_d[1] = 1'b1;
							end
							rhp_pkg::FLD_CHANNEL: begin
								freq_d    = gather_new[15:0];
								chflags_d = gather_new[31:16];
								seen_d[0] = 1'b1;
							end
							rhp_pkg::FLD_SIGNAL: begin
								signal_d  = gather_new[7:0];
								seen_d[2] = 1'b1;
							end
							rhp_pkg::FLD_NOISE: begin
								noise_d   = gather_new[7:0];
								seen_d[3] = 1'b1;
							end
							default: ;
						endcase
						cursor_d = next_field(fbits_q, cursor_q + 4'd1);
						count_d  = 4'd0;
						gather_d = 32'd0;
					end else begin
						count_d  = count_new;
						gather_d = gather_new;
					end
				end
			end
		end
	end

	// frame summary from the state after this byte
	always_comb begin
		len17     = 17'(off_d);
		hsum17    = {1'b0, hlen_d} + (fcs_d ? 17'(rhp_pkg::FCS_BYTES) : 17'd0);
		plen16    = 16'(off_d) - hlen_d - {13'd0, fcs_d, 2'b00};
		rate_half = rate_d[6:1];
		result    = '0;
		if (len17 < 17'(rhp_pkg::MIN_HDR))
			result.status = rhp_pkg::ST_SHORT;
		else if (len17 < {1'b0, hlen_d})
			result.status = rhp_pkg::ST_HDR_SHORT;
		else if (overrun_d || !done_d)
			result.status = rhp_pkg::ST_OVERRUN;
		else if (hsum17 > len17)
			result.status = rhp_pkg::ST_FCS_SHORT;
		else
			result.status = rhp_pkg::ST_OK;
		if (result.status == rhp_pkg::ST_OK) begin
			result.frequency      = freq_d;
			if (seen_d[0]) begin
				result.carrier  = carrier_of(chflags_d);
				result.encoding = encoding_of(chflags_d);
			end
			result.data_rate      = 10'({rate_half, 3'b000}) + 10'({rate_half, 1'b0});
			result.signal_level   = signal_d;
			result.noise_level    = noise_d;
			result.fcs_present    = fcs_d;
			result.payload_length = plen16[12:0];
			result.seen_mask      = seen_d;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			s1_q <= in_data;
		end
	end

	// parse state, cleared after each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			hlen_q    <= '0;
			fbits_q   <= '0;
			done_q    <= 1'b0;
			overrun_q <= 1'b0;
			cursor_q  <= '0;
			count_q   <= '0;
			gather_q  <= '0;
			freq_q    <= '0;
			chflags_q <= '0;
			rate_q    <= '0;
			signal_q  <= '0;
			noise_q   <= '0;
			fcs_q     <= 1'b0;
			seen_q    <= '0;
		end else if (s1_go) begin
			if (s1_q.last_byte) begin
				off_q     <= '0;
				hlen_q    <= '0;
				fbits_q   <= '0;
				done_q    <= 1'b0;
				overrun_q <= 1'b0;
				cursor_q  <= '0;
				count_q   <= '0;
				gather_q  <= '0;
				freq_q    <= '0;
				chflags_q <= '0;
				rate_q    <= '0;
				signal_q  <= '0;
				noise_q   <= '0;
				fcs_q     <= 1'b0;
				seen_q    <= '0;
			end else begin
				off_q     <= off_d;
				hlen_q    <= hlen_d;
				fbits_q   <= fbits_d;
				done_q    <= done_d;
				overrun_q <= overrun_d;
				cursor_q  <= cursor_d;
				count_q   <= count_d;
				gather_q  <= gather_d;
				freq_q    <= freq_d;
				chflags_q <= chflags_d;
				rate_q    <= rate_d;
				signal_q  <= signal_d;
				noise_q   <= noise_d;
				fcs_q     <= fcs_d;
				seen_q    <= seen_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_q.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_q.last_byte) begin
			out_q <= result;
		end
	end

	// checks
	`RHP_ASSERT_IMP(a_err_fields_zero, out_valid_q && out_q.status != rhp_pkg::ST_OK, out_q.seen_mask == 4'd0 && out_q.payload_length == 13'd0 && out_q.frequency == 16'd0)
	`RHP_ASSERT_IMP(a_chain_exclusive, 1'b1, !(done_q && overrun_q))
	`RHP_ASSERT_IMP(a_offset_bound, 1'b1, off_q <= OW'(rhp_pkg::MAX_FRAME) && cursor_q <= rhp_pkg::FLD_NONE)
	`RHP_ASSERT_NEXT(a_last_closes_frame, s1_go && s1_q.last_byte, out_valid_q && off_q == '0 && !done_q)
	`RHP_ASSERT_IMP(a_carrier_needs_channel, out_valid_q && out_q.carrier != rhp_pkg::CAR_UNKNOWN, out_q.seen_mask[0])

endmodule
